@@ rtl/pevc_pkg.sv @@
package pevc_pkg;

   localparam int MAX_KEYS_DEF = 10;
   localparam int CODE_SLOTS   = 10;

   localparam int CODE_W    = 20;
   localparam int LEN_W     = 4;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_KEY   = 2'd1,
      CMD_OK    = 2'd2,
      CMD_BACK  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_NONE   = 2'd0,
      STATUS_ACCEPT = 2'd1,
      STATUS_EXIT   = 2'd2
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_CODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOW_UPDATE   = 2'd2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [1:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              back_consumed;
      logic              mode;
      logic              active_entry;
      logic [LEN_W-1:0]  entry_length;
      logic [CODE_W-1:0] saved_code;
      logic [LEN_W-1:0]  saved_length;
   } rsp_type;

   typedef struct packed {
      logic [CODE_W-1:0] initial_code;
      logic [LEN_W-1:0]  initial_length;
      logic              allow_update;
   } cfg_type;

endpackage

@@ rtl/pevc_if.sv @@
interface pevc_req_if
   import pevc_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [1:0] key;

   modport source (output valid, output cmd, output key, input ready);
   modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface pevc_rsp_if
   import pevc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic              back_consumed;
   logic              mode;
   logic              active_entry;
   logic [LEN_W-1:0]  entry_length;
   logic [CODE_W-1:0] saved_code;
   logic [LEN_W-1:0]  saved_length;

   modport source (output valid, output status, output back_consumed, output mode,
                   output active_entry, output entry_length, output saved_code,
                   output saved_length, input ready);
   modport sink   (input valid, input status, input back_consumed, input mode,
                   input active_entry, input entry_length, input saved_code,
                   input saved_length, output ready);
endinterface

interface pevc_csr_if
   import pevc_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CODE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/pin_entry_verify_and_change_unit.sv @@
// Path: a request word accepted into the input register is stepped by the core
// into the response register, from which it is taken.
// Throughput: one word per cycle, set by the single-pass step logic between
// the two registers; a stalled response side stops the input once the input
// register is also full.
// Reset (synchronous, active high) clears the mode, entry counts, stored code
// and configuration registers; key entry buffers hold no reset value.
module pin_entry_verify_and_change_unit
   import pevc_pkg::*;
#(
   parameter int MAX_KEYS = MAX_KEYS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   pevc_req_if.sink    req_if,
   pevc_rsp_if.source  rsp_if,
   pevc_csr_if.sink    csr_if
);

   cfg_type cfg;
   req_type req_item;
   req_type stage_item;
   logic    stage_valid;
   logic    stage_take;
   rsp_type rsp_item;

   assign req_item.cmd = req_if.cmd;
   assign req_item.key = req_if.key;

   pevc_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_if.valid),
      .wr_index (csr_if.index),
      .wr_data  (csr_if.data),
      .wr_ready (csr_if.ready),
      .cfg      (cfg)
   );

   pevc_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_item   (req_item),
      .in_ready  (req_if.ready),
      .out_valid (stage_valid),
      .out_item  (stage_item),
      .out_take  (stage_take)
   );

   pevc_lock_core #(
      .MAX_KEYS (MAX_KEYS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (stage_valid),
      .in_item   (stage_item),
      .in_take   (stage_take),
      .rsp_valid (rsp_if.valid),
      .rsp_item  (rsp_item),
      .rsp_ready (rsp_if.ready)
   );

   assign rsp_if.status        = rsp_item.status;
   assign rsp_if.back_consumed = rsp_item.back_consumed;
   assign rsp_if.mode          = rsp_item.mode;
   assign rsp_if.active_entry  = rsp_item.active_entry;
   assign rsp_if.entry_length  = rsp_item.entry_length;
   assign rsp_if.saved_code    = rsp_item.saved_code;
   assign rsp_if.saved_length  = rsp_item.saved_length;

endmodule

@@ rtl/pevc_csr_regs.sv @@
module pevc_csr_regs
   import pevc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   input  logic [CSR_IDX_W-1:0] wr_index,
   input  logic [CODE_W-1:0]    wr_data,
   output logic                 wr_ready,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (wr_index)
            CSR_INITIAL_CODE:   cfg_in.initial_code   = wr_data;
            CSR_INITIAL_LENGTH: cfg_in.initial_length = wr_data[LEN_W-1:0];
            CSR_ALLOW_UPDATE:   cfg_in.allow_update   = wr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/pevc_in_stage.sv @@
module pevc_in_stage
   import pevc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_item,
   output logic    in_ready,
   output logic    out_valid,
   output req_type out_item,
   input  logic    out_take
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   // The stage refills in the same cycle that the core takes its word.
   assign in_ready  = !valid_ff || out_take;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (out_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

@@ rtl/pevc_lock_core.sv @@
module pevc_lock_core
   import pevc_pkg::*;
#(
   parameter int MAX_KEYS = MAX_KEYS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   input  req_type in_item,
   output logic    in_take,
   output logic    rsp_valid,
   output rsp_type rsp_item,
   input  logic    rsp_ready
);

   localparam int CW    = $clog2(MAX_KEYS + 1);
   localparam int SLOTS = (MAX_KEYS > CODE_SLOTS) ? MAX_KEYS : CODE_SLOTS;
   localparam int PK    = (MAX_KEYS < CODE_SLOTS) ? MAX_KEYS : CODE_SLOTS;

   logic          mode_ff, mode_in;
   logic          sel_ff, sel_in;
   logic [CW-1:0] first_cnt_ff, first_cnt_in;
   logic [CW-1:0] repeat_cnt_ff, repeat_cnt_in;
   logic [CW-1:0] code_cnt_ff, code_cnt_in;
   logic [1:0]    first_keys_ff  [MAX_KEYS];
   logic [1:0]    first_keys_in  [MAX_KEYS];
   logic [1:0]    repeat_keys_ff [MAX_KEYS];
   logic [1:0]    repeat_keys_in [MAX_KEYS];
   logic [1:0]    code_keys_ff   [MAX_KEYS];
   logic [1:0]    code_keys_in   [MAX_KEYS];

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic [2*SLOTS-1:0] init_ext;
   logic [CW-1:0]      start_len;
   logic [CW-1:0]      act_cnt;
   logic               verify_hit;
   logic               change_hit;
   logic               verify_miss_any;
   logic               change_miss_any;
   logic [CW-1:0]      next_act_cnt;
   logic [CODE_W-1:0]  packed_code;

   assign in_take   = in_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign init_ext = (2*SLOTS)'(cfg.initial_code);
   assign act_cnt  = sel_ff ? repeat_cnt_ff : first_cnt_ff;

   always_comb begin
      if (32'(cfg.initial_length) > MAX_KEYS) begin
         start_len = CW'(MAX_KEYS);
      end else begin
         start_len = CW'(cfg.initial_length);
      end
   end

   // Masked equality over all key positions; empty or unequal lengths never match.
   always_comb begin
      verify_miss_any = 1'b0;
      change_miss_any = 1'b0;
      for (int i = 0; i < MAX_KEYS; i++) begin
         if (i < 32'(first_cnt_ff) && first_keys_ff[i] != code_keys_ff[i]) begin
            verify_miss_any = 1'b1;
         end
         if (i < 32'(first_cnt_ff) && repeat_keys_ff[i] != first_keys_ff[i]) begin
            change_miss_any = 1'b1;
         end
      end
      verify_hit = (first_cnt_ff != '0) && (first_cnt_ff == code_cnt_ff) && !verify_miss_any;
      change_hit = (first_cnt_ff != '0) && (first_cnt_ff == repeat_cnt_ff) && !change_miss_any;
   end

   always_comb begin
      mode_in        = mode_ff;
      sel_in         = sel_ff;
      first_cnt_in   = first_cnt_ff;
      repeat_cnt_in  = repeat_cnt_ff;
      code_cnt_in    = code_cnt_ff;
      first_keys_in  = first_keys_ff;
      repeat_keys_in = repeat_keys_ff;
      code_keys_in   = code_keys_ff;
      rsp_in         = rsp_ff;
      rsp_in.status        = STATUS_NONE;
      rsp_in.back_consumed = 1'b0;

      case (cmd_type'(in_item.cmd))
         CMD_START: begin
            for (int i = 0; i < MAX_KEYS; i++) begin
               code_keys_in[i] = init_ext[2*i +: 2];
            end
            code_cnt_in   = start_len;
            sel_in        = 1'b0;
            first_cnt_in  = '0;
            repeat_cnt_in = '0;
            mode_in       = (start_len == '0);
         end
         CMD_KEY: begin
            // A key on a full entry is dropped.
            if (32'(act_cnt) < MAX_KEYS) begin
               for (int i = 0; i < MAX_KEYS; i++) begin
                  if (i == 32'(act_cnt)) begin
                     if (sel_ff) begin
                        repeat_keys_in[i] = in_item.key;
                     end else begin
                        first_keys_in[i] = in_item.key;
                     end
                  end
               end
               if (sel_ff) begin
                  repeat_cnt_in = repeat_cnt_ff + 1'b1;
               end else begin
                  first_cnt_in = first_cnt_ff + 1'b1;
               end
            end
         end
         CMD_OK: begin
            if (!mode_ff) begin
               if (verify_hit) begin
                  if (cfg.allow_update) begin
                     mode_in = 1'b1;
                  end else begin
                     rsp_in.status = STATUS_ACCEPT;
                  end
               end
               if (sel_ff) begin
                  repeat_cnt_in = '0;
               end else begin
                  first_cnt_in = '0;
               end
            end else if (!sel_ff && first_cnt_ff != '0) begin
               sel_in = 1'b1;
            end else if (change_hit) begin
               // Only the typed positions are copied into the stored code.
               if (cfg.allow_update) begin
                  for (int i = 0; i < MAX_KEYS; i++) begin
                     if (i < 32'(first_cnt_ff)) begin
                        code_keys_in[i] = first_keys_ff[i];
                     end
                  end
                  code_cnt_in = first_cnt_ff;
               end
               rsp_in.status = STATUS_ACCEPT;
            end else begin
               if (sel_ff) begin
                  repeat_cnt_in = '0;
               end else begin
                  first_cnt_in = '0;
               end
            end
         end
         CMD_BACK: begin
            if (sel_ff && act_cnt == '0) begin
               sel_in               = 1'b0;
               rsp_in.back_consumed = 1'b1;
            end else if (act_cnt != '0) begin
               if (sel_ff) begin
                  repeat_cnt_in = '0;
               end else begin
                  first_cnt_in = '0;
               end
               rsp_in.back_consumed = 1'b1;
            end else begin
               rsp_in.status = STATUS_EXIT;
            end
         end
         default: begin
            rsp_in.status = STATUS_NONE;
         end
      endcase

      next_act_cnt = sel_in ? repeat_cnt_in : first_cnt_in;
      packed_code  = '0;
      for (int i = 0; i < PK; i++) begin
         if (i < 32'(code_cnt_in)) begin
            packed_code[2*i +: 2] = code_keys_in[i];
         end
      end

      rsp_in.mode         = mode_in;
      rsp_in.active_entry = sel_in;
      rsp_in.entry_length = LEN_W'(32'(next_act_cnt));
      rsp_in.saved_code   = packed_code;
      rsp_in.saved_length = LEN_W'(32'(code_cnt_in));
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (in_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         sel_ff        <= 1'b0;
         first_cnt_ff  <= '0;
         repeat_cnt_ff <= '0;
         code_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < MAX_KEYS; i++) begin
            code_keys_ff[i] <= 2'b00;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (in_take) begin
            mode_ff       <= mode_in;
            sel_ff        <= sel_in;
            first_cnt_ff  <= first_cnt_in;
            repeat_cnt_ff <= repeat_cnt_in;
            code_cnt_ff   <= code_cnt_in;
            code_keys_ff  <= code_keys_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         first_keys_ff  <= first_keys_in;
         repeat_keys_ff <= repeat_keys_in;
         rsp_ff         <= rsp_in;
      end
   end

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(first_cnt_ff) <= MAX_KEYS && 32'(repeat_cnt_ff) <= MAX_KEYS
      && 32'(code_cnt_ff) <= MAX_KEYS)
      else $error("entry or code count beyond the key limit");

   a_start_mode: assert property (@(posedge clock) disable iff (reset)
      in_take && in_item.cmd == CMD_START
      |=> mode_ff == (code_cnt_ff == '0) && !sel_ff && first_cnt_ff == '0)
      else $error("start did not set the mode from the stored length");

   a_key_grows: assert property (@(posedge clock) disable iff (reset)
      in_take && in_item.cmd == CMD_KEY && !sel_ff && 32'(first_cnt_ff) < MAX_KEYS
      |=> first_cnt_ff == $past(first_cnt_ff) + 1'b1)
      else $error("key press did not extend the first entry");

   a_exit_not_consumed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == STATUS_EXIT |-> !rsp_ff.back_consumed)
      else $error("exit request flagged as consumed");

   a_rsp_follows_take: assert property (@(posedge clock) disable iff (reset)
      in_take |=> rsp_valid_ff)
      else $error("taken word produced no response");

endmodule

@@ bench/lock_check_pkg.sv @@
package lock_check_pkg;
   import pevc_pkg::*;

   // Tracks the keypad lock from the words accepted on its input side and
   // holds the response words that are still due, oldest first.
   class lock_scoreboard;
      logic [CODE_W-1:0] reg_code;
      logic [LEN_W-1:0]  reg_length;
      logic              reg_allow;

      logic       change_mode;
      logic       on_repeat;
      logic [1:0] first_keys[MAX_KEYS_DEF];
      logic [1:0] repeat_keys[MAX_KEYS_DEF];
      logic [1:0] code_keys[MAX_KEYS_DEF];
      int         first_len;
      int         repeat_len;
      int         code_len;

      rsp_type    awaited_q[$];
      int         errors;

      function new();
         reg_code    = '0;
         reg_length  = '0;
         reg_allow   = 1'b0;
         change_mode = 1'b0;
         on_repeat   = 1'b0;
         first_len   = 0;
         repeat_len  = 0;
         code_len    = 0;
         errors      = 0;
         foreach (code_keys[i]) begin
            code_keys[i]   = 2'd0;
            first_keys[i]  = 2'd0;
            repeat_keys[i] = 2'd0;
         end
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CODE_W-1:0] data);
         case (idx)
            CSR_INITIAL_CODE:   reg_code   = data;
            CSR_INITIAL_LENGTH: reg_length = data[LEN_W-1:0];
            CSR_ALLOW_UPDATE:   reg_allow  = data[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return awaited_q.size();
      endfunction

      function int active_len();
         return on_repeat ? repeat_len : first_len;
      endfunction

      function void clear_active();
         if (on_repeat) begin
            repeat_len = 0;
         end else begin
            first_len = 0;
         end
      endfunction

      // Two entries match only when both are non-empty and of equal length.
      function bit keys_match(logic [1:0] a[MAX_KEYS_DEF], int na,
                              logic [1:0] b[MAX_KEYS_DEF], int nb);
         if (na == 0 || nb == 0 || na != nb) return 1'b0;
         for (int i = 0; i < na; i++) begin
            if (a[i] !== b[i]) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_request(cmd_type c, logic [1:0] k);
         rsp_type w;
         int      len;
         w = '0;
         case (c)
            CMD_START: begin
               foreach (code_keys[i]) code_keys[i] = reg_code[2*i +: 2];
               len         = (reg_length > MAX_KEYS_DEF) ? MAX_KEYS_DEF : int'(reg_length);
               code_len    = len;
               on_repeat   = 1'b0;
               first_len   = 0;
               repeat_len  = 0;
               change_mode = (code_len == 0);
            end
            CMD_KEY: begin
               // A key typed into a full entry is simply lost.
               if (on_repeat) begin
                  if (repeat_len < MAX_KEYS_DEF) begin
                     repeat_keys[repeat_len] = k;
                     repeat_len++;
                  end
               end else if (first_len < MAX_KEYS_DEF) begin
                  first_keys[first_len] = k;
                  first_len++;
               end
            end
            CMD_OK: begin
               if (!change_mode) begin
                  if (keys_match(first_keys, first_len, code_keys, code_len)) begin
                     if (reg_allow) begin
                        change_mode = 1'b1;
                     end else begin
                        w.status = STATUS_ACCEPT;
                     end
                  end
                  clear_active();
               end else if (!on_repeat && first_len != 0) begin
                  on_repeat = 1'b1;
               end else if (keys_match(repeat_keys, repeat_len, first_keys, first_len)) begin
                  if (reg_allow) begin
                     for (int i = 0; i < first_len; i++) code_keys[i] = first_keys[i];
                     code_len = first_len;
                  end
                  w.status = STATUS_ACCEPT;
               end else begin
                  clear_active();
               end
            end
            default: begin
               if (on_repeat && repeat_len == 0) begin
                  on_repeat       = 1'b0;
                  w.back_consumed = 1'b1;
               end else if (active_len() != 0) begin
                  clear_active();
                  w.back_consumed = 1'b1;
               end else begin
                  w.status = STATUS_EXIT;
               end
            end
         endcase
         w.mode         = change_mode;
         w.active_entry = on_repeat;
         w.entry_length = LEN_W'(active_len());
         w.saved_length = LEN_W'(code_len);
         for (int i = 0; i < code_len; i++) w.saved_code[2*i +: 2] = code_keys[i];
         awaited_q.push_back(w);
      endfunction

      function void check_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited_q.size() == 0) begin
            $display("%0t: response word %h arrived with nothing expected", $time, got);
            errors++;
            return;
         end
         want = awaited_q.pop_front();
         check_field("status", 32'(want.status), 32'(got.status));
         check_field("back_consumed", 32'(want.back_consumed), 32'(got.back_consumed));
         check_field("mode", 32'(want.mode), 32'(got.mode));
         check_field("active_entry", 32'(want.active_entry), 32'(got.active_entry));
         check_field("entry_length", 32'(want.entry_length), 32'(got.entry_length));
         check_field("saved_code", 32'(want.saved_code), 32'(got.saved_code));
         check_field("saved_length", 32'(want.saved_length), 32'(got.saved_length));
      endfunction
   endclass

endpackage

@@ bench/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pevc_pkg::*;
   import lock_check_pkg::*;

   localparam int IDLE_LIMIT      = 1000;
   localparam int PRESSURE_CYCLES = 80;
   localparam int PHASES          = 8;
   localparam int PHASE_ITEMS     = 128;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pevc_req_if req_if();
   pevc_rsp_if rsp_if();
   pevc_csr_if csr_if();

   pin_entry_verify_and_change_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   lock_scoreboard lock_model;
   rsp_type        got_word;
   logic           gaps_on      = 1'b0;
   logic           stalls_on    = 1'b0;
   logic           hold_request = 1'b0;
   int             idle_cycles  = 0;
   int             sent_items   = 0;

   assign got_word = {rsp_if.status, rsp_if.back_consumed, rsp_if.mode, rsp_if.active_entry,
                      rsp_if.entry_length, rsp_if.saved_code, rsp_if.saved_length};

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) lock_model.write_register(csr_if.index, csr_if.data);
         if (req_if.valid && req_if.ready) lock_model.note_request(cmd_type'(req_if.cmd),
                                                                   req_if.key);
         if (rsp_if.valid && rsp_if.ready) lock_model.check_response(got_word);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Mostly short pauses, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 15) return $urandom_range(1, 3);
      if (r < 19) return $urandom_range(4, 8);
      return $urandom_range(9, 30);
   endfunction

   // Response side: random stalls, plus one long hold-off on request.
   initial begin : rsp_side
      int hold;
      hold = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_if.ready = 1'b0;
            hold--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold = PRESSURE_CYCLES - 1;
            rsp_if.ready = 1'b0;
         end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            hold = pick_gap() - 1;
            rsp_if.ready = 1'b0;
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   // Called and left at a falling edge; valid is left high on return.
   task automatic send_word(cmd_type c, logic [1:0] k);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_if.valid = 1'b0;
         repeat (pick_gap()) @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.cmd   = c;
      req_if.key   = k;
      do @(posedge clock); while (!req_if.ready);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CODE_W-1:0] data);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data  = data;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic settle();
      req_if.valid = 1'b0;
      while (lock_model.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic configure(int ph);
      case (ph)
         0: begin
            write_reg(CSR_INITIAL_CODE, '0);
            write_reg(CSR_INITIAL_LENGTH, 20'd0);
            write_reg(CSR_ALLOW_UPDATE, 20'd1);
         end
         1: begin
            write_reg(CSR_INITIAL_CODE, 20'hFFFFF);
            write_reg(CSR_INITIAL_LENGTH, 20'd10);
            write_reg(CSR_ALLOW_UPDATE, 20'd0);
         end
         2: begin
            write_reg(CSR_INITIAL_CODE, 20'($urandom));
            write_reg(CSR_INITIAL_LENGTH, 20'd15);
            write_reg(CSR_ALLOW_UPDATE, 20'd1);
         end
         3: begin
            write_reg(CSR_INITIAL_CODE, 20'($urandom));
            write_reg(CSR_INITIAL_LENGTH, 20'd1);
            write_reg(CSR_ALLOW_UPDATE, 20'd1);
         end
         default: begin
            write_reg(CSR_INITIAL_CODE, 20'($urandom));
            write_reg(CSR_INITIAL_LENGTH, 20'($urandom_range(0, 15)));
            write_reg(CSR_ALLOW_UPDATE, 20'($urandom_range(0, 1)));
         end
      endcase
   endtask

   // One burst of user behaviour: mostly well-formed code entries, some noise.
   task automatic run_episode();
      logic [1:0] typed[12];
      int         n;
      int         r;
      int         j;
      r = $urandom_range(0, 99);
      if (r < 6) begin
         send_word(CMD_START, 2'($urandom_range(0, 3)));
      end else if (r < 46) begin
         // Try the stored code, sometimes slightly wrong.
         n = (lock_model.code_len == 0) ? $urandom_range(1, 3) : lock_model.code_len;
         for (int i = 0; i < 12; i++) begin
            typed[i] = (i < lock_model.code_len) ? lock_model.code_keys[i]
                                                 : 2'($urandom_range(0, 3));
         end
         case ($urandom_range(0, 5))
            0: begin
               j = $urandom_range(0, n - 1);
               typed[j] = typed[j] ^ 2'($urandom_range(1, 3));
            end
            1: n = n + 1;
            2: n = n - 1;
            default: ;
         endcase
         for (int i = 0; i < n; i++) send_word(CMD_KEY, typed[i]);
         send_word(CMD_OK, 2'($urandom_range(0, 3)));
      end else if (r < 76) begin
         // A new code typed twice, the repeat sometimes differing.
         r = $urandom_range(0, 19);
         if (r < 15) n = $urandom_range(1, 6);
         else if (r < 18) n = $urandom_range(7, 10);
         else if (r < 19) n = 10;
         else n = $urandom_range(11, 12);
         for (int i = 0; i < 12; i++) typed[i] = 2'($urandom_range(0, 3));
         for (int i = 0; i < n; i++) send_word(CMD_KEY, typed[i]);
         send_word(CMD_OK, 2'($urandom_range(0, 3)));
         case ($urandom_range(0, 7))
            0: begin
               j = $urandom_range(0, n - 1);
               typed[j] = typed[j] ^ 2'($urandom_range(1, 3));
            end
            1: n = $urandom_range(0, 12);
            default: ;
         endcase
         for (int i = 0; i < n; i++) send_word(CMD_KEY, typed[i]);
         send_word(CMD_OK, 2'($urandom_range(0, 3)));
      end else if (r < 88) begin
         n = $urandom_range(0, 3);
         for (int i = 0; i < n; i++) send_word(CMD_KEY, 2'($urandom_range(0, 3)));
         if ($urandom_range(0, 1) == 1) send_word(CMD_OK, 2'($urandom_range(0, 3)));
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) send_word(CMD_BACK, 2'($urandom_range(0, 3)));
      end else begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) begin
            send_word(cmd_type'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
         end
      end
   endtask

   initial begin : stimulus
      int first_item;
      lock_model   = new();
      req_if.valid = 1'b0;
      req_if.cmd   = CMD_START;
      req_if.key   = 2'd0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_INITIAL_CODE;
      csr_if.data  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Before any start the stored code is empty, so nothing can verify.
      send_word(CMD_OK, 2'd0);
      send_word(CMD_BACK, 2'd0);
      send_word(CMD_KEY, 2'd0);
      send_word(CMD_BACK, 2'd0);
      // An empty code at start goes straight to change mode; saving is off.
      send_word(CMD_START, 2'd0);
      send_word(CMD_KEY, 2'd1);
      send_word(CMD_KEY, 2'd2);
      send_word(CMD_OK, 2'd0);
      send_word(CMD_BACK, 2'd0);
      send_word(CMD_OK, 2'd0);
      send_word(CMD_KEY, 2'd1);
      send_word(CMD_KEY, 2'd2);
      send_word(CMD_OK, 2'd0);
      send_word(CMD_OK, 2'd0);
      settle();

      // An over-long length saturates; the eleventh key lands in a full entry.
      write_reg(CSR_INITIAL_CODE, 20'hFFFFF);
      write_reg(CSR_INITIAL_LENGTH, 20'd15);
      write_reg(CSR_ALLOW_UPDATE, 20'd1);
      send_word(CMD_START, 2'd3);
      repeat (11) send_word(CMD_KEY, 2'd3);
      send_word(CMD_OK, 2'd0);

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         configure(ph);
         gaps_on   = (ph % 2) == 1;
         stalls_on = ((ph / 2) % 2) == 1;
         if (ph == 2 || ph == 6) hold_request = 1'b1;
         first_item = sent_items;
         send_word(CMD_START, 2'($urandom_range(0, 3)));
         while (sent_items - first_item < PHASE_ITEMS) run_episode();
      end

      settle();
      if (lock_model.errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
